// ===== hw/rtl/tepq_pkg.sv =====
// ----------------------------------------------------------------------------
// Timed event priority queue package
// Shared types and codes for the queue cells and the queue controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tepq_pkg;

    localparam int TICK_W    = 64;
    localparam int PRIO_W    = 8;
    localparam int FIELD_ID_W = 8;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 7;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 96;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_POP    = 2'd2,
        FN_NOP    = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_POP
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_WAVE
    } state_t;

    typedef struct packed {
        logic [TICK_W-1:0]        tick;
        logic signed [PRIO_W-1:0] prio;
    } key_t;

    typedef struct packed {
        cell_op_t op;
        key_t     key;
    } cell_cmd_t;

    // remove search token moving from head to tail, one cell per cycle
    typedef struct packed {
        logic tok;
        logic found;
    } wave_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tepq_cell.sv =====
// ----------------------------------------------------------------------------
// Queue cell
// Holds one sorted entry; inserts, shifts with its neighbors and passes the
// remove search token toward the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module tepq_cell
    import tepq_pkg::*;
#(
    parameter int ID_BITS = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cell_cmd_t          cmd,
    input  wire logic [ID_BITS-1:0] new_id,
    input  wire logic [ID_BITS-1:0] rm_id,
    input  wire logic               occ,
    input  wire logic [ID_BITS-1:0] left_id,
    input  wire key_t               left_key,
    input  wire logic               left_le,
    input  wire logic [ID_BITS-1:0] right_id,
    input  wire key_t               right_key,
    input  wire wave_t              wave_in,
    input  wire logic [ID_BITS-1:0] wave_id_in,
    input  wire key_t               wave_key_in,
    output logic [ID_BITS-1:0]      id_o,
    output key_t                    key_o,
    output logic                    le_o,
    output wave_t                   wave_o,
    output logic [ID_BITS-1:0]      wave_id_o,
    output key_t                    wave_key_o
);

    logic [ID_BITS-1:0] id_reg, id_next;
    key_t               key_reg, key_next;
    wave_t              wave_reg, wave_next;
    logic [ID_BITS-1:0] wave_id_reg, wave_id_next;
    key_t               wave_key_reg, wave_key_next;
    logic               key_le;
    logic               match;

    assign key_le = (cmd.key.tick < key_reg.tick) ||
                    ((cmd.key.tick == key_reg.tick) && (cmd.key.prio <= key_reg.prio));
    assign le_o   = !occ || key_le;
    assign match  = occ && (id_reg == rm_id);

    always_comb begin
        id_next       = id_reg;
        key_next      = key_reg;
        wave_next.tok   = wave_in.tok;
        wave_next.found = wave_in.tok && (wave_in.found || match);
        wave_id_next  = wave_id_in;
        wave_key_next = wave_key_in;
        case (cmd.op)
            OP_INSERT: begin
                if (left_le) begin
                    id_next  = left_id;
                    key_next = left_key;
                end else if (le_o) begin
                    id_next  = new_id;
                    key_next = cmd.key;
                end
            end
            OP_POP: begin
                id_next  = right_id;
                key_next = right_key;
            end
            default: begin
            end
        endcase
        if (wave_in.tok && (wave_in.found || match)) begin
            id_next  = right_id;
            key_next = right_key;
            if (!wave_in.found) begin
                wave_id_next  = id_reg;
                wave_key_next = key_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg <= '0;
        end else begin
            wave_reg <= wave_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg       <= id_next;
        key_reg      <= key_next;
        wave_id_reg  <= wave_id_next;
        wave_key_reg <= wave_key_next;
    end

    assign id_o       = id_reg;
    assign key_o      = key_reg;
    assign wave_o     = wave_reg;
    assign wave_id_o  = wave_id_reg;
    assign wave_key_o = wave_key_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/timed_event_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Timed event priority queue
// Sorted queue of timed events built from a chain of cells; insert, remove
// by id and pop head.
// ----------------------------------------------------------------------------
// channel | dir | handshake         | contents
// s_      | in  | s_tvalid/s_tready | func, event_id, due_tick, event_priority
// m_      | out | m_tvalid/m_tready | out_id, out_tick, out_priority, status,
//         |     |                   | fill_level
//
// Insert, pop, no-op and remove on an empty queue load the result as accepted.
// A remove with entries present sends the search token down the whole cell
// chain, one cell per cycle, closes up the gap and loads the result at the tail.
// One result register; in idle, a new item is taken once it is free or being taken.
// aresetn empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_priority_queue_unit
    import tepq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int ID_BITS     = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [1:0] func, [9:2] event_id, [73:10] due_tick, [81:74] event_priority
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [7:0] out_id, [71:8] out_tick, [79:72] out_priority, [81:80] status,
    // [88:82] fill_level
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 start_reg, start_next;
    logic [ID_BITS-1:0]   rm_id_reg, rm_id_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                 s_accept;
    func_t                func_in;
    logic [ID_BITS-1:0]   id_in;
    key_t                 key_in;
    cell_cmd_t            cmd;
    logic                 full;
    logic                 load;
    logic [ID_BITS-1:0]   o_id;
    key_t                 o_key;
    status_t              o_status;

    logic [ID_BITS-1:0]   id_arr      [QUEUE_DEPTH];
    key_t                 key_arr     [QUEUE_DEPTH];
    logic                 le_arr      [QUEUE_DEPTH];
    wave_t                wave_arr    [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   wave_id_arr [QUEUE_DEPTH];
    key_t                 wave_key_arr[QUEUE_DEPTH];

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign func_in  = func_t'(s_tdata[1:0]);
    assign id_in    = ID_BITS'(s_tdata[9:2]);
    assign key_in.tick = s_tdata[73:10];
    assign key_in.prio = s_tdata[81:74];
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            logic [ID_BITS-1:0] l_id, r_id, w_id;
            key_t               l_key, r_key, w_key;
            logic               l_le;
            wave_t              w_in;
            logic               occ;

            assign occ = (CNT_W'(i) < count_reg);

            if (i == 0) begin : g_head
                assign l_id  = id_in;
                assign l_key = key_in;
                assign l_le  = 1'b0;
                assign w_in.tok   = start_reg;
                assign w_in.found = 1'b0;
                assign w_id  = '0;
                assign w_key = '0;
            end else begin : g_body
                assign l_id  = id_arr[i-1];
                assign l_key = key_arr[i-1];
                assign l_le  = le_arr[i-1];
                assign w_in  = wave_arr[i-1];
                assign w_id  = wave_id_arr[i-1];
                assign w_key = wave_key_arr[i-1];
            end

            if (i == QUEUE_DEPTH - 1) begin : g_tail
                assign r_id  = '0;
                assign r_key = '0;
            end else begin : g_inner
                assign r_id  = id_arr[i+1];
                assign r_key = key_arr[i+1];
            end

            tepq_cell #(
                .ID_BITS (ID_BITS)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .cmd         (cmd),
                .new_id      (id_in),
                .rm_id       (rm_id_reg),
                .occ         (occ),
                .left_id     (l_id),
                .left_key    (l_key),
                .left_le     (l_le),
                .right_id    (r_id),
                .right_key   (r_key),
                .wave_in     (w_in),
                .wave_id_in  (w_id),
                .wave_key_in (w_key),
                .id_o        (id_arr[i]),
                .key_o       (key_arr[i]),
                .le_o        (le_arr[i]),
                .wave_o      (wave_arr[i]),
                .wave_id_o   (wave_id_arr[i]),
                .wave_key_o  (wave_key_arr[i])
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        start_next = 1'b0;
        rm_id_next = rm_id_reg;
        cmd.op     = OP_HOLD;
        cmd.key    = key_in;
        load       = 1'b0;
        o_id       = '0;
        o_key      = '0;
        o_status   = ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    case (func_in)
                        FN_INSERT: begin
                            load = 1'b1;
                            if (full) begin
                                o_status = ST_FULL;
                            end else begin
                                cmd.op     = OP_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_REMOVE: begin
                            if (count_reg == '0) begin
                                load     = 1'b1;
                                o_status = ST_NOTFOUND;
                            end else begin
                                start_next = 1'b1;
                                rm_id_next = id_in;
                                state_next = S_WAVE;
                            end
                        end
                        FN_POP: begin
                            load = 1'b1;
                            if (count_reg == '0) begin
                                o_status = ST_EMPTY;
                            end else begin
                                cmd.op     = OP_POP;
                                o_id       = id_arr[0];
                                o_key      = key_arr[0];
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            S_WAVE: begin
                if (wave_arr[QUEUE_DEPTH-1].tok) begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    if (wave_arr[QUEUE_DEPTH-1].found) begin
                        o_id       = wave_id_arr[QUEUE_DEPTH-1];
                        o_key      = wave_key_arr[QUEUE_DEPTH-1];
                        count_next = count_reg - CNT_W'(1);
                    end else begin
                        o_status = ST_NOTFOUND;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        m_valid_next = load ? 1'b1 : (m_valid_reg && !m_tready);
        m_data_next  = load ? {7'd0, FILL_W'(count_next), o_status, o_key.prio,
                               o_key.tick, FIELD_ID_W'(o_id)}
                            : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rm_id_reg  <= rm_id_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== tb/timed_event_priority_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Timed event priority queue testbench
// Drives insert, remove and pop operations over the input stream. A
// behavioral copy of the sorted queue predicts every result, and each result
// transfer is checked field by field. Both stream sides idle at random, and
// the result side is held off for a long stretch to fill the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_event_priority_queue_unit_tb;
    import tepq_pkg::*;

    localparam int DEPTH      = 64;
    localparam int MAX_GAP    = 12;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_WAIT  = DEPTH + 16;

    typedef struct packed {
        logic [7:0]               id;
        logic [TICK_W-1:0]        tick;
        logic signed [PRIO_W-1:0] prio;
        status_t                  status;
        logic [FILL_W-1:0]        fill;
    } queue_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // [1:0] func, [9:2] event_id, [73:10] due_tick, [81:74] event_priority
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // [7:0] out_id, [71:8] out_tick, [79:72] out_priority, [81:80] status,
    // [88:82] fill_level
    logic [M_TDATA_W-1:0] m_tdata;

    // shadow of the sorted queue, head at index 0
    logic [7:0]               shadow_id   [DEPTH];
    logic [TICK_W-1:0]        shadow_tick [DEPTH];
    logic signed [PRIO_W-1:0] shadow_prio [DEPTH];
    int                       shadow_count;

    queue_result_t pending_results[$];
    int            error_count;
    int            idle_cycles;
    int            rx_hold_cycles;
    bit            tx_no_gaps;
    bit            rx_no_gaps;

    timed_event_priority_queue_unit #(
        .QUEUE_DEPTH (DEPTH),
        .ID_BITS     (8)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic queue_result_t predict_queue_op(logic [S_TDATA_W-1:0] word);
        func_t                    f;
        logic [7:0]               id;
        logic [TICK_W-1:0]        tick;
        logic signed [PRIO_W-1:0] prio;
        queue_result_t            r;
        int                       pos;
        f    = func_t'(word[1:0]);
        id   = word[9:2];
        tick = word[73:10];
        prio = word[81:74];
        r    = '0;
        r.status = ST_OK;
        case (f)
            FN_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = shadow_count;
                    for (int i = shadow_count - 1; i >= 0; i--) begin
                        if (tick < shadow_tick[i] ||
                            (tick == shadow_tick[i] && prio <= shadow_prio[i]))
                            pos = i;
                    end
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_id[i]   = shadow_id[i-1];
                        shadow_tick[i] = shadow_tick[i-1];
                        shadow_prio[i] = shadow_prio[i-1];
                    end
                    shadow_id[pos]   = id;
                    shadow_tick[pos] = tick;
                    shadow_prio[pos] = prio;
                    shadow_count++;
                end
            end
            FN_REMOVE, FN_POP: begin
                pos = -1;
                if (f == FN_POP) begin
                    if (shadow_count > 0) pos = 0;
                end else begin
                    for (int i = shadow_count - 1; i >= 0; i--)
                        if (shadow_id[i] == id) pos = i;
                end
                if (pos < 0) begin
                    r.status = (f == FN_POP) ? ST_EMPTY : ST_NOTFOUND;
                end else begin
                    r.id   = shadow_id[pos];
                    r.tick = shadow_tick[pos];
                    r.prio = shadow_prio[pos];
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_id[i]   = shadow_id[i+1];
                        shadow_tick[i] = shadow_tick[i+1];
                        shadow_prio[i] = shadow_prio[i+1];
                    end
                    shadow_count--;
                end
            end
            default: ;
        endcase
        r.fill = shadow_count[FILL_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        error_count++;
    endtask

    // result check first, then prediction of the transfer taken at the same edge
    always @(posedge aclk) begin
        queue_result_t got;
        queue_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.id     = m_tdata[7:0];
                got.tick   = m_tdata[71:8];
                got.prio   = m_tdata[79:72];
                got.status = status_t'(m_tdata[81:80]);
                got.fill   = m_tdata[88:82];
                if (pending_results.size() == 0) begin
                    $display("[%0t] result transfer with none outstanding", $time);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.id != want.id)
                        report_mismatch("out_id", 64'(got.id), 64'(want.id));
                    if (got.tick != want.tick)
                        report_mismatch("out_tick", got.tick, want.tick);
                    if (got.prio != want.prio)
                        report_mismatch("out_priority", 64'(got.prio), 64'(want.prio));
                    if (got.status != want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.fill != want.fill)
                        report_mismatch("fill_level", 64'(got.fill), 64'(want.fill));
                end
            end
            if (s_tvalid && s_tready)
                pending_results = {pending_results, predict_queue_op(s_tdata)};
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $time, idle_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stall per transfer, long hold-off on request
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = rx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_op(func_t f, logic [7:0] id, logic [TICK_W-1:0] tick,
                           logic signed [PRIO_W-1:0] prio);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, prio, tick, id, f};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [TICK_W-1:0] pick_tick();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return {$urandom, $urandom};
            4:       return {32'hFFFF_FFFF, 28'hFFF_FFFF, 4'($urandom_range(0, 15))};
            default: return TICK_W'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic signed [PRIO_W-1:0] pick_prio();
        if ($urandom_range(0, 1))
            return PRIO_W'($urandom_range(0, 255));
        return PRIO_W'($urandom_range(0, 4) - 2);
    endfunction

    task automatic test_empty_queue();
        send_op(FN_POP, 8'h00, '0, '0);
        send_op(FN_REMOVE, 8'h05, '0, '0);
        send_op(FN_NOP, 8'hFF, '1, -8'sd1);
    endtask

    task automatic test_ordering_extremes();
        send_op(FN_INSERT, 8'h00, '1, 8'sd127);
        send_op(FN_INSERT, 8'hFF, '0, -8'sd128);
        send_op(FN_INSERT, 8'h5A, 64'd100, 8'sd0);
        send_op(FN_INSERT, 8'hA5, 64'd100, 8'sd0);
        send_op(FN_INSERT, 8'h33, 64'd100, -8'sd1);
        send_op(FN_INSERT, 8'h34, 64'd100, 8'sd127);
        send_op(FN_REMOVE, 8'h5A, '0, '0);
        send_op(FN_REMOVE, 8'h77, '0, '0);
        // second entry with a live id, lands nearer the head
        send_op(FN_INSERT, 8'h33, 64'd50, 8'sd5);
        send_op(FN_REMOVE, 8'h33, '0, '0);
        send_op(FN_NOP, 8'hAA, 64'h5555_AAAA_5555_AAAA, 8'sh55);
        repeat (6) send_op(FN_POP, 8'h00, '0, '0);
    endtask

    task automatic test_fill_under_backpressure();
        int live;
        wait_for_drain();
        live = shadow_count;
        repeat (live) send_op(FN_POP, 8'h00, '0, '0);
        rx_hold_cycles = 200;
        tx_no_gaps = 1'b1;
        repeat (DEPTH + 6)
            send_op(FN_INSERT, 8'($urandom_range(0, 255)), pick_tick(), pick_prio());
        tx_no_gaps = 1'b0;
        repeat (DEPTH + 2) send_op(FN_POP, 8'h00, '0, '0);
    endtask

    task automatic test_random_mix(int n_items);
        int         sel;
        logic [7:0] id;
        for (int n = 0; n < n_items; n++) begin
            if (n % 100 == 50) wait_for_drain();
            if (n % 80 == 0) begin
                tx_no_gaps = $urandom_range(0, 2) == 0;
                rx_no_gaps = $urandom_range(0, 2) == 0;
            end
            sel = $urandom_range(0, 99);
            if (shadow_count > 56 && sel < 45) sel = 80;
            if (sel < 45) begin
                send_op(FN_INSERT, 8'($urandom_range(0, 255)), pick_tick(), pick_prio());
            end else if (sel < 70 && shadow_count > 0) begin
                id = shadow_id[$urandom_range(0, shadow_count - 1)];
                send_op(FN_REMOVE, id, pick_tick(), pick_prio());
            end else if (sel < 76) begin
                send_op(FN_REMOVE, 8'($urandom_range(0, 255)), pick_tick(), pick_prio());
            end else if (sel < 96) begin
                send_op(FN_POP, 8'($urandom_range(0, 255)), pick_tick(), pick_prio());
            end else begin
                send_op(FN_NOP, 8'($urandom_range(0, 255)), pick_tick(), pick_prio());
            end
        end
        tx_no_gaps = 1'b0;
        rx_no_gaps = 1'b0;
    endtask

    initial begin
        error_count    = 0;
        shadow_count   = 0;
        rx_hold_cycles = 0;
        tx_no_gaps     = 1'b0;
        rx_no_gaps     = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_ordering_extremes();
        test_fill_under_backpressure();
        test_random_mix(400);

        wait_for_drain();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tepq_pkg.sv
hw/rtl/tepq_cell.sv
hw/rtl/timed_event_priority_queue_unit.sv
tb/timed_event_priority_queue_unit_tb.sv
